// ===== sv/rbr_pkg.sv =====
// rbr_pkg: shared constants, types and pointer helpers of the ring buffer resampler
`default_nettype none
package rbr_pkg;

  // ring geometry
  localparam int RING_DEPTH = 4096;
  localparam int CHANNELS   = 2;
  localparam int PTR_WRAP   = 2 * RING_DEPTH;
  localparam int AW         = $clog2(RING_DEPTH);
  localparam int PW         = $clog2(PTR_WRAP);

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int CH_W     = 3;
  localparam int STEP_W   = 20;
  localparam int FRAC_W   = 16;
  localparam int WHOLE_W  = STEP_W + 1 - FRAC_W;
  localparam int OFS_W    = CH_W + 1;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_PULL = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_S0,
    ST_RD_S1,
    ST_MUL,
    ST_OUT,
    ST_ADV
  } state_e;

  // pointer plus a small offset, modulo twice the ring depth
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [OFS_W-1:0] n);
    logic [PW:0] s;
    s = {1'b0, p} + (PW+1)'(n);
    if (s >= (PW+1)'(PTR_WRAP)) begin
      s = s - (PW+1)'(PTR_WRAP);
    end
    return s[PW-1:0];
  endfunction

  // memory address of a pointer
  function automatic logic [AW-1:0] store_index(input logic [PW-1:0] p);
    logic [PW-1:0] i;
    i = p;
    if (p >= PW'(RING_DEPTH)) begin
      i = p - PW'(RING_DEPTH);
    end
    return i[AW-1:0];
  endfunction

  // samples stored between read and write pointer
  function automatic logic [PW-1:0] fill_of(input logic [PW-1:0] w, input logic [PW-1:0] r);
    logic [PW:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + (PW+1)'(PTR_WRAP) - {1'b0, r};
    end
    return d[PW-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rbr_in_if.sv =====
// rbr_in_if: input channel carrying push and pull beats
`default_nettype none
interface rbr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [rbr_pkg::SAMPLE_W-1:0] sample_in;

  modport source (output valid, output opcode, output sample_in, input ready);
  modport sink   (input valid, input opcode, input sample_in, output ready);
endinterface
`default_nettype wire

// ===== sv/rbr_out_if.sv =====
// rbr_out_if: output channel carrying one channel sample per beat
`default_nettype none
interface rbr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [rbr_pkg::SAMPLE_W-1:0] sample_out;
  logic [rbr_pkg::CH_W-1:0]            channel_index;
  logic                                last_of_frame;
  logic                                underflow;

  modport source (output valid, output sample_out, output channel_index,
                  output last_of_frame, output underflow, input ready);
  modport sink   (input valid, input sample_out, input channel_index,
                  input last_of_frame, input underflow, output ready);
endinterface
`default_nettype wire

// ===== sv/rbr_mem.sv =====
// rbr_mem: sample ring memory, one write port and one registered read port
`default_nettype none
module rbr_mem (
  input  wire logic                                clk_i,
  input  wire logic                                we_i,
  input  wire logic [rbr_pkg::AW-1:0]              waddr_i,
  input  wire logic signed [rbr_pkg::SAMPLE_W-1:0] wdata_i,
  input  wire logic [rbr_pkg::AW-1:0]              raddr_i,
  output logic signed [rbr_pkg::SAMPLE_W-1:0]      rdata_o
);

  logic signed [rbr_pkg::SAMPLE_W-1:0] mem_q [rbr_pkg::RING_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== sv/rbr_interp.sv =====
// rbr_interp: shared interpolation unit, s0 + floor((s1 - s0) * frac / 65536)
`default_nettype none
module rbr_interp (
  input  wire logic                                clk_i,
  input  wire logic                                load_i,
  input  wire logic signed [rbr_pkg::SAMPLE_W-1:0] s0_i,
  input  wire logic signed [rbr_pkg::SAMPLE_W-1:0] s1_i,
  input  wire logic [rbr_pkg::FRAC_W-1:0]          frac_i,
  output logic signed [rbr_pkg::SAMPLE_W-1:0]      val_o
);

  localparam int DW = rbr_pkg::SAMPLE_W + 1;
  localparam int MW = 2 * DW;

  logic signed [DW-1:0]               diff;
  logic signed [DW-1:0]               frac_x;
  logic signed [MW-1:0]               prod_d;
  logic signed [MW-1:0]               prod_q;
  logic signed [rbr_pkg::SAMPLE_W-1:0] s0_q;
  logic signed [MW-rbr_pkg::FRAC_W-1:0] shifted;
  logic signed [MW-rbr_pkg::FRAC_W-1:0] sum;

  // difference times fraction
  always_comb begin
    diff   = DW'(s1_i) - DW'(s0_i);
    frac_x = {1'b0, frac_i};
    prod_d = MW'(diff) * MW'(frac_x);
  end

  // product stage
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
      s0_q   <= s0_i;
    end
  end

  // arithmetic shift gives the floor, the sum stays between s0 and s1
  always_comb begin
    shifted = prod_q[MW-1:rbr_pkg::FRAC_W];
    sum     = shifted + (MW-rbr_pkg::FRAC_W)'(s0_q);
    val_o   = sum[rbr_pkg::SAMPLE_W-1:0];
  end

endmodule
`default_nettype wire

// ===== sv/ring_buffer_linear_resampler.sv =====
// ring_buffer_linear_resampler: top level with sequencer, pointers and output register
// Interleaved multichannel ring buffer with a linear interpolation rate converter.
// A push beat stores one Q1.15 sample, dropping the oldest sample when the ring is
// full. A pull beat gives one frame of CHANNELS output beats, one per channel. The
// sequencer reads two samples per channel from the single read port of the ring
// memory and runs them through one shared multiplier, then advances the read pointer
// by W, the number of whole frames consumed (one frame a cycle, up to 16, clamped to
// the frames stored); an underflow frame skips the reads and the advance. Output
// stalls hold the sequencer. rate_step is Q4.16 source frames per device frame; the
// user must write it through cfg_we_i / cfg_data_i only while the block is idle, the
// block itself does not enforce this. The ring memory is not cleared at reset.
`default_nettype none
module ring_buffer_linear_resampler (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [rbr_pkg::STEP_W-1:0]         cfg_data_i,
  rbr_in_if.sink                                  in_i,
  rbr_out_if.source                               out_o
);

  localparam int PW = rbr_pkg::PW;

  rbr_pkg::state_e                     state_q, state_d;
  logic [PW-1:0]                       wp_q, wp_d;
  logic [PW-1:0]                       rp_q, rp_d;
  logic [rbr_pkg::FRAC_W-1:0]          frac_q, frac_d;
  logic [rbr_pkg::FRAC_W-1:0]          nfrac_q, nfrac_d;
  logic [rbr_pkg::STEP_W-1:0]          step_q;
  logic [rbr_pkg::WHOLE_W-1:0]         whole_q, whole_d;
  logic [PW-1:0]                       fill_q, fill_d;
  logic [rbr_pkg::CH_W-1:0]            ch_q, ch_d;
  logic                                under_q, under_d;
  logic signed [rbr_pkg::SAMPLE_W-1:0] s0_q, s0_d;
  logic                                out_valid_q, out_valid_d;
  logic signed [rbr_pkg::SAMPLE_W-1:0] out_sample_q;
  logic [rbr_pkg::CH_W-1:0]            out_ch_q;
  logic                                out_last_q;
  logic                                out_under_q;

  logic [PW-1:0]                       fill;
  logic [rbr_pkg::STEP_W:0]            pos;
  logic                                last_ch;
  logic                                out_load;
  logic                                mem_we;
  logic [rbr_pkg::AW-1:0]              raddr;
  logic signed [rbr_pkg::SAMPLE_W-1:0] rdata;
  logic                                mul_load;
  logic signed [rbr_pkg::SAMPLE_W-1:0] interp_val;

  rbr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (rbr_pkg::store_index(wp_q)),
    .wdata_i (in_i.sample_in),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  rbr_interp u_interp (
    .clk_i  (clk_i),
    .load_i (mul_load),
    .s0_i   (s0_q),
    .s1_i   (rdata),
    .frac_i (frac_q),
    .val_o  (interp_val)
  );

  // pull-side helpers
  always_comb begin
    fill    = rbr_pkg::fill_of(wp_q, rp_q);
    pos     = (rbr_pkg::STEP_W+1)'(frac_q) + (rbr_pkg::STEP_W+1)'(step_q);
    last_ch = (ch_q == rbr_pkg::CH_W'(rbr_pkg::CHANNELS - 1));
  end

  // read address: frame 1 sample only while fetching it
  always_comb begin
    if (state_q == rbr_pkg::ST_RD_S1) begin
      raddr = rbr_pkg::store_index(rbr_pkg::ptr_add(rp_q,
                rbr_pkg::OFS_W'(rbr_pkg::CHANNELS) + rbr_pkg::OFS_W'(ch_q)));
    end else begin
      raddr = rbr_pkg::store_index(rbr_pkg::ptr_add(rp_q, rbr_pkg::OFS_W'(ch_q)));
    end
  end

  // sequencer: next state and datapath enables
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    frac_d      = frac_q;
    nfrac_d     = nfrac_q;
    whole_d     = whole_q;
    fill_d      = fill_q;
    ch_d        = ch_q;
    under_d     = under_q;
    s0_d        = s0_q;
    in_i.ready  = 1'b0;
    mem_we      = 1'b0;
    mul_load    = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      rbr_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          if (rbr_pkg::opcode_e'(in_i.opcode) == rbr_pkg::OP_PUSH) begin
            mem_we = 1'b1;
            wp_d   = rbr_pkg::ptr_add(wp_q, rbr_pkg::OFS_W'(1));
            if (fill >= PW'(rbr_pkg::RING_DEPTH)) begin
              rp_d = rbr_pkg::ptr_add(rp_q, rbr_pkg::OFS_W'(1));
            end
          end else begin
            ch_d    = '0;
            fill_d  = fill;
            whole_d = pos[rbr_pkg::STEP_W:rbr_pkg::FRAC_W];
            nfrac_d = pos[rbr_pkg::FRAC_W-1:0];
            under_d = (fill < PW'(2 * rbr_pkg::CHANNELS));
            state_d = (fill < PW'(2 * rbr_pkg::CHANNELS)) ? rbr_pkg::ST_OUT
                                                         : rbr_pkg::ST_RD_S0;
          end
        end
      end
      rbr_pkg::ST_RD_S0: begin
        state_d = rbr_pkg::ST_RD_S1;
      end
      rbr_pkg::ST_RD_S1: begin
        s0_d    = rdata;
        state_d = rbr_pkg::ST_MUL;
      end
      rbr_pkg::ST_MUL: begin
        mul_load = 1'b1;
        state_d  = rbr_pkg::ST_OUT;
      end
      rbr_pkg::ST_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          if (!last_ch) begin
            ch_d    = ch_q + rbr_pkg::CH_W'(1);
            state_d = under_q ? rbr_pkg::ST_OUT : rbr_pkg::ST_RD_S0;
          end else begin
            state_d = under_q ? rbr_pkg::ST_IDLE : rbr_pkg::ST_ADV;
          end
        end
      end
      rbr_pkg::ST_ADV: begin
        // one whole frame a cycle, clamped to the frames stored
        if ((whole_q != '0) && (fill_q >= PW'(rbr_pkg::CHANNELS))) begin
          rp_d    = rbr_pkg::ptr_add(rp_q, rbr_pkg::OFS_W'(rbr_pkg::CHANNELS));
          fill_d  = fill_q - PW'(rbr_pkg::CHANNELS);
          whole_d = whole_q - rbr_pkg::WHOLE_W'(1);
        end else begin
          frac_d  = nfrac_q;
          state_d = rbr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rbr_pkg::ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbr_pkg::ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      frac_q      <= '0;
      step_q      <= rbr_pkg::STEP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      frac_q      <= frac_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        step_q <= cfg_data_i;
      end
    end
  end

  // per-pull working registers
  always_ff @(posedge clk_i) begin
    nfrac_q <= nfrac_d;
    whole_q <= whole_d;
    fill_q  <= fill_d;
    ch_q    <= ch_d;
    under_q <= under_d;
    s0_q    <= s0_d;
  end

  // output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_sample_q <= under_q ? '0 : interp_val;
      out_ch_q     <= ch_q;
      out_last_q   <= last_ch;
      out_under_q  <= under_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.sample_out    = out_sample_q;
  assign out_o.channel_index = out_ch_q;
  assign out_o.last_of_frame = out_last_q;
  assign out_o.underflow     = out_under_q;

endmodule
`default_nettype wire

// ===== tb/resampler_frame_check.sv =====
// resampler_frame_check: watches both channels, predicts each output beat and compares
`timescale 1ns / 100ps
module resampler_frame_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rbr_pkg::STEP_W-1:0] cfg_data_i,
  rbr_in_if                          in_mon_i,
  rbr_out_if                         out_mon_i,
  output int                         mismatch_count_o,
  output int                         beats_due_o
);
  import rbr_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [CH_W-1:0]            chan;
    logic                       last;
    logic                       under;
  } out_beat_t;

  // expected output beats, oldest first
  out_beat_t frame_beats_q[$];

  // predicted ring contents and position
  logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [PW-1:0]              wr_ptr;
  logic [PW-1:0]              rd_ptr;
  logic [FRAC_W-1:0]          frac_pos;
  logic [STEP_W-1:0]          step_q;
  int                         fails;
  out_beat_t                  got;
  out_beat_t                  want;

  // samples held, pointers count modulo twice the depth
  function automatic logic [PW-1:0] stored_samples();
    return wr_ptr - rd_ptr;
  endfunction

  // push: drop the oldest sample when full, then write
  task automatic store_sample(input logic signed [SAMPLE_W-1:0] s);
    if (stored_samples() >= PW'(RING_DEPTH)) begin
      rd_ptr = rd_ptr + 1'b1;
    end
    ring_mem[wr_ptr[AW-1:0]] = s;
    wr_ptr = wr_ptr + 1'b1;
  endtask

  // pull: one interpolated frame, then advance by the whole frames of the step
  task automatic predict_frame();
    int            frames;
    int            whole;
    int            pos;
    int            s0;
    int            s1;
    longint        prod;
    logic [PW-1:0] p;
    bit            starved;
    out_beat_t     b;
    frames  = int'(stored_samples()) / CHANNELS;
    starved = (frames < 2);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      b.sample = '0;
      if (!starved) begin
        p    = rd_ptr + PW'(ch);
        s0   = ring_mem[p[AW-1:0]];
        p    = rd_ptr + PW'(CHANNELS + ch);
        s1   = ring_mem[p[AW-1:0]];
        prod = longint'(s1 - s0) * longint'(frac_pos);
        // arithmetic shift rounds toward minus infinity
        b.sample = SAMPLE_W'(s0 + int'(prod >>> FRAC_W));
      end
      b.chan  = CH_W'(ch);
      b.last  = (ch == CHANNELS - 1);
      b.under = starved;
      frame_beats_q.push_back(b);
    end
    if (!starved) begin
      pos   = int'(frac_pos) + int'(step_q);
      whole = pos >>> FRAC_W;
      // never consume more than is stored
      if (whole > frames) begin
        whole = frames;
      end
      rd_ptr   = rd_ptr + PW'(whole * CHANNELS);
      frac_pos = pos[FRAC_W-1:0];
    end
  endtask

  // monitor: compare output beats, track config and input beats
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr   = '0;
      rd_ptr   = '0;
      frac_pos = '0;
      step_q   = STEP_RESET;
      fails    = 0;
      frame_beats_q.delete();
      mismatch_count_o <= 0;
      beats_due_o      <= 0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = {out_mon_i.sample_out, out_mon_i.channel_index,
               out_mon_i.last_of_frame, out_mon_i.underflow};
        if (frame_beats_q.size() == 0) begin
          fails++;
          $display("%0t: output beat with none expected, actual sample %0d ch %0d last %0b under %0b",
                   $time, $signed(got.sample), got.chan, got.last, got.under);
        end else begin
          want = frame_beats_q.pop_front();
          if (got !== want) begin
            fails++;
            $display("%0t: output beat mismatch, expected sample %0d ch %0d last %0b under %0b",
                     $time, $signed(want.sample), want.chan, want.last, want.under);
            $display("%0t:                       actual   sample %0d ch %0d last %0b under %0b",
                     $time, $signed(got.sample), got.chan, got.last, got.under);
          end
        end
      end
      if (cfg_we_i) begin
        step_q = cfg_data_i;
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        if (in_mon_i.opcode == OP_PULL) begin
          predict_frame();
        end else begin
          store_sample(in_mon_i.sample_in);
        end
      end
      mismatch_count_o <= fails;
      beats_due_o      <= frame_beats_q.size();
    end
  end

endmodule

// ===== tb/ring_buffer_linear_resampler_test.sv =====
// ring_buffer_linear_resampler_test: stimulus, handshake idling and verdict for the resampler
`timescale 1ns / 100ps
module ring_buffer_linear_resampler_test;
  import rbr_pkg::*;

  localparam int RUN_LIMIT     = 250000;
  localparam int SETTLE_CYCLES = 48;
  localparam int RANDOM_ITEMS  = 410;
  localparam logic [STEP_W-1:0] STEP_MAX  = '1;
  localparam logic [STEP_W-1:0] STEP_ZERO = '0;
  localparam logic [STEP_W-1:0] STEP_MIN  = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_3_2  = STEP_W'(98304);
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [STEP_W-1:0] cfg_data_i;
  int                mismatch_count;
  int                beats_due;
  bit                idle_on;

  rbr_in_if  in_ch ();
  rbr_out_if out_ch ();

  ring_buffer_linear_resampler DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  resampler_frame_check frame_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_mon_i         (in_ch),
    .out_mon_i        (out_ch),
    .mismatch_count_o (mismatch_count),
    .beats_due_o      (beats_due)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (RUN_LIMIT) @(posedge clk_i);
    $display("FAIL ring_buffer_linear_resampler");
    $finish;
  end

  // random sample, extremes now and then
  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(0, 15))
      0:       return S_MAX;
      1:       return S_MIN;
      2:       return '0;
      3:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // random step, mostly near unity
  function automatic logic [STEP_W-1:0] any_step();
    case ($urandom_range(0, 9))
      0:       return STEP_MIN;
      1:       return STEP_MAX;
      2:       return STEP_RESET;
      3, 4:    return STEP_W'($urandom_range(1, 1048575));
      default: return STEP_W'($urandom_range(32768, 131072));
    endcase
  endfunction

  // one input beat; valid stays high when the next beat follows at once
  task automatic send_beat(input opcode_e op, input logic signed [SAMPLE_W-1:0] s);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.opcode    <= op;
    in_ch.sample_in <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  // hold off input until every expected beat is out and the block has settled
  task automatic drain_outputs();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // step register write while idle
  task automatic write_step(input logic [STEP_W-1:0] step);
    drain_outputs();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= step;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // output side: random stall before each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  // stimulus
  initial begin
    int burst;
    int phase;
    int sent;
    int count;
    int pull_pct;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = OP_PUSH;
    in_ch.sample_in = '0;
    idle_on         = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty and single frame underflow, then a plain frame at unit step
    send_beat(OP_PULL, S_MAX);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PULL, '0);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PULL, '0);

    // zero step repeats the same frame
    write_step(STEP_ZERO);
    send_beat(OP_PUSH, 16'sd1);
    send_beat(OP_PUSH, -16'sd1);
    send_beat(OP_PULL, '0);
    send_beat(OP_PULL, '0);

    // step of one and a half, half-way interpolation across full-scale swings
    write_step(STEP_3_2);
    send_beat(OP_PULL, '0);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PULL, '0);
    send_beat(OP_PULL, '0);

    // largest step runs past the stored data, then the largest fraction
    write_step(STEP_MAX);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PULL, '0);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MIN);
    send_beat(OP_PUSH, S_MAX);
    send_beat(OP_PULL, '0);

    // random phases, each with its own step, pull mix and idling
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_step((phase == 0) ? STEP_MIN : any_step());
      idle_on = ($urandom_range(0, 3) != 0);
      // one flood past the ring depth, odd counts shift channel alignment
      if (phase == 3) begin
        burst = RING_DEPTH + $urandom_range(1, 9);
        repeat (burst) send_beat(OP_PUSH, any_sample());
      end
      pull_pct = $urandom_range(15, 60);
      count    = $urandom_range(20, 50);
      while (count > 0) begin
        if ($urandom_range(0, 99) < pull_pct) begin
          send_beat(OP_PULL, any_sample());
          count--;
          sent++;
        end else if ($urandom_range(0, 9) == 0) begin
          // lone sample breaks frame alignment
          send_beat(OP_PUSH, any_sample());
          count--;
          sent++;
        end else begin
          repeat (CHANNELS) send_beat(OP_PUSH, any_sample());
          count -= CHANNELS;
          sent  += CHANNELS;
        end
      end
      phase++;
    end

    drain_outputs();
    if (mismatch_count == 0 && beats_due == 0) begin
      $display("PASS ring_buffer_linear_resampler");
    end else begin
      $display("FAIL ring_buffer_linear_resampler");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/rbr_pkg.sv
sv/rbr_in_if.sv
sv/rbr_out_if.sv
sv/rbr_mem.sv
sv/rbr_interp.sv
sv/ring_buffer_linear_resampler.sv
tb/resampler_frame_check.sv
tb/ring_buffer_linear_resampler_test.sv
